// ----- rtl/scdk_pkg.sv -----
// ----------------------------------------------------------------------------
// scdk_pkg: shared types and constants for the key-matrix deframer
// Frame layout constants, configuration register indexes, the frame beat
// carried along the CRC cell chain and the byte-wide CRC-8 step.
// ----------------------------------------------------------------------------
`default_nettype none

package scdk_pkg;

  localparam int NUM_COLUMNS_DEF = 16;

  localparam logic [7:0] SYNC_A      = 8'd55;
  localparam logic [7:0] SYNC_B      = 8'd66;
  localparam logic [7:0] PAYLOAD_LEN = 8'd3;
  localparam int         HEAD_LEN    = 5;
  localparam int         FRAME_LEN   = 8;
  localparam int         WIN_CELLS   = FRAME_LEN - 1;

  localparam logic [1:0] ROLE_LID = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_OWN_ROLE = 2'd0;
  localparam logic [1:0] REG_CRC_POLY = 2'd1;

  // Payload byte positions
  localparam logic [1:0] PAY_ROW   = 2'd0;
  localparam logic [1:0] PAY_COL   = 2'd1;
  localparam logic [1:0] PAY_PRESS = 2'd2;

  typedef struct packed {
    logic            valid;
    logic [7:0]      crc_acc;
    logic [7:0]      crc_byte;
    logic [7:0]      sender;
    logic [2:0][7:0] pay;
  } frame_t;

  // One byte of CRC-8, MSB first; data already holds acc ^ byte
  function automatic logic [7:0] crc_step(input logic [7:0] data, input logic [7:0] poly);
    logic [7:0] c;
    c = data;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sync_crc_deframer_key_matrix_top.sv -----
// ----------------------------------------------------------------------------
// Path: frame register, the three CRC cells, then the output register.
// Throughput: one byte per cycle while in_stall is low; frames and window
//   slides add no stall. The frame register and the three-cell CRC chain
//   hold up to four frames in flight, the output register one more update.
// Reset (rst_n low, synchronous): window empty, key matrix all released,
//   own_role 0, crc_polynomial 0x07, chain and output register empty.
// ----------------------------------------------------------------------------
// sync_crc_deframer_key_matrix_top: sync-word deframer driving a key matrix
// Slide received bytes through a row of byte cells, check the header as the
// eighth byte arrives, run CRC-8 over the payload in a chain of cells, then
// update the key matrix and present the changed column.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_crc_deframer_key_matrix_top #(
  parameter int NUM_COLUMNS = scdk_pkg::NUM_COLUMNS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Receive byte channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_rx_byte,
  // Key update channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [2:0] out_key_row,
  output logic      [3:0] out_key_column,
  output logic            out_key_pressed,
  output logic      [7:0] out_column_bits,
  // Configuration write channel
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam int WIN   = scdk_pkg::WIN_CELLS;

  // --------------------------------------------------------------------------
  // Configuration registers; writes are always taken
  // --------------------------------------------------------------------------
  logic [1:0] own_role_r, own_role_nxt;
  logic [7:0] crc_poly_r, crc_poly_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    own_role_nxt = own_role_r;
    crc_poly_nxt = crc_poly_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        scdk_pkg::REG_OWN_ROLE: own_role_nxt = cfg_data[1:0];
        scdk_pkg::REG_CRC_POLY: crc_poly_nxt = cfg_data;
        default: ;  // indexes beyond the register list are ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_role_r <= 2'd0;
      crc_poly_r <= 8'h07;
    end else begin
      own_role_r <= own_role_nxt;
      crc_poly_r <= crc_poly_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Receive window: seven byte cells, newest in the top cell. The incoming
  // beat is the eighth byte of the window, so a full frame is checked in the
  // same cycle it completes.
  // --------------------------------------------------------------------------
  logic       in_accept;
  logic [7:0] win [WIN];

  assign in_accept = in_valid && !in_stall;

  for (genvar i = 0; i < WIN; i++) begin : g_win
    logic [7:0] cell_d;
    if (i == WIN - 1) begin : g_top
      assign cell_d = in_rx_byte;
    end else begin : g_mid
      assign cell_d = win[i+1];
    end
    scdk_byte_cell u_cell (
      .clk      (clk),
      .shift_en (in_accept),
      .d        (cell_d),
      .q        (win[i])
    );
  end

  // Fill count of the window, 0..7; eight bytes is never stored
  logic [2:0] fill_r, fill_nxt;
  logic       win_full;
  logic       hdr_ok;

  assign win_full = (fill_r == 3'(WIN));
  assign hdr_ok   = (win[0] == scdk_pkg::SYNC_A) && (win[1] == scdk_pkg::SYNC_B) &&
                    (win[2] == scdk_pkg::PAYLOAD_LEN);

  always_comb begin
    fill_nxt = fill_r;
    if (in_accept) begin
      if (!win_full) begin
        fill_nxt = fill_r + 3'd1;
      end else if (hdr_ok) begin
        fill_nxt = 3'd0;  // frame consumed
      end
      // header mismatch: drop the oldest byte, count stays at seven
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 3'd0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Frame register feeding the CRC chain
  // --------------------------------------------------------------------------
  scdk_pkg::frame_t s0_r, s0_nxt;
  scdk_pkg::frame_t s1, s2, s3;
  logic             free0, free1, free2, free3;
  logic             last_free;

  assign free0    = !s0_r.valid || free1;
  // Stall only while the frame register is blocked by a backed-up chain
  assign in_stall = !free0;

  always_comb begin
    s0_nxt = s0_r;
    if (free0) begin
      s0_nxt.valid    = in_accept && win_full && hdr_ok;
      s0_nxt.crc_acc  = 8'd0;
      s0_nxt.crc_byte = win[3];
      s0_nxt.sender   = win[4];
      s0_nxt.pay[scdk_pkg::PAY_ROW]   = win[5];
      s0_nxt.pay[scdk_pkg::PAY_COL]   = win[6];
      s0_nxt.pay[scdk_pkg::PAY_PRESS] = in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else begin
      s0_r <= s0_nxt;
    end
  end

  // CRC chain: one payload byte per cell
  scdk_crc_cell #(.SEL(scdk_pkg::PAY_ROW)) u_crc0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_poly  (crc_poly_r),
    .prev      (s0_r),
    .next_free (free2),
    .free      (free1),
    .cur       (s1)
  );

  scdk_crc_cell #(.SEL(scdk_pkg::PAY_COL)) u_crc1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_poly  (crc_poly_r),
    .prev      (s1),
    .next_free (free3),
    .free      (free2),
    .cur       (s2)
  );

  scdk_crc_cell #(.SEL(scdk_pkg::PAY_PRESS)) u_crc2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_poly  (crc_poly_r),
    .prev      (s2),
    .next_free (last_free),
    .free      (free3),
    .cur       (s3)
  );

  // --------------------------------------------------------------------------
  // Frame decision and key matrix update
  // --------------------------------------------------------------------------
  logic             sender_ok;
  logic             crc_ok;
  logic             row_ok;
  logic             col_ok;
  logic             emit;
  logic             free_o;
  logic             take;
  logic [COL_W-1:0] col_idx;
  logic [7:0]       row_mask;
  logic [7:0]       col_new;
  logic             pressed;

  assign sender_ok = (s3.sender != {6'd0, own_role_r});
  assign crc_ok    = (s3.crc_acc == s3.crc_byte);
  assign row_ok    = (s3.pay[scdk_pkg::PAY_ROW][7:3] == 5'd0);
  assign col_ok    = ({1'b0, s3.pay[scdk_pkg::PAY_COL]} < 9'(NUM_COLUMNS));
  assign emit      = sender_ok && crc_ok && (own_role_r == scdk_pkg::ROLE_LID) &&
                     row_ok && col_ok;

  assign free_o    = !out_valid || !out_stall;
  // Drop frames that fail a check; hold an update until the output frees
  assign last_free = !emit || free_o;
  assign take      = s3.valid && emit && free_o;

  assign col_idx  = s3.pay[scdk_pkg::PAY_COL][COL_W-1:0];
  assign row_mask = 8'd1 << s3.pay[scdk_pkg::PAY_ROW][2:0];
  assign pressed  = (s3.pay[scdk_pkg::PAY_PRESS] != 8'd0);

  logic [7:0] key_matrix_r [NUM_COLUMNS];

  always_comb begin
    if (pressed) begin
      col_new = key_matrix_r[col_idx] | row_mask;
    end else begin
      col_new = key_matrix_r[col_idx] & ~row_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        key_matrix_r[c] <= 8'd0;
      end
    end else if (take) begin
      key_matrix_r[col_idx] <= col_new;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_row_r;
  logic [3:0] out_col_r;
  logic       out_pressed_r;
  logic [7:0] out_bits_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (free_o) begin
      out_valid_nxt = take;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_row_r     <= s3.pay[scdk_pkg::PAY_ROW][2:0];
      out_col_r     <= s3.pay[scdk_pkg::PAY_COL][3:0];
      out_pressed_r <= pressed;
      out_bits_r    <= col_new;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_key_row     = out_row_r;
  assign out_key_column  = out_col_r;
  assign out_key_pressed = out_pressed_r;
  assign out_column_bits = out_bits_r;

endmodule

`default_nettype wire

// ----- rtl/scdk_byte_cell.sv -----
// ----------------------------------------------------------------------------
// scdk_byte_cell: one byte of the receive window
// Hold a byte and pass it to the older neighbor on every accepted beat.
// ----------------------------------------------------------------------------
`default_nettype none

module scdk_byte_cell (
  input  wire logic       clk,
  input  wire logic       shift_en,
  input  wire logic [7:0] d,
  output logic      [7:0] q
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = shift_en ? d : byte_r;
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

  assign q = byte_r;

endmodule

`default_nettype wire

// ----- rtl/scdk_crc_cell.sv -----
// ----------------------------------------------------------------------------
// scdk_crc_cell: one link of the CRC chain
// Fold one payload byte into the running CRC-8 and hand the frame onward.
// ----------------------------------------------------------------------------
`default_nettype none

module scdk_crc_cell #(
  parameter logic [1:0] SEL = scdk_pkg::PAY_ROW
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [7:0]      crc_poly,
  input  wire scdk_pkg::frame_t prev,
  input  wire logic            next_free,
  output logic                 free,
  output scdk_pkg::frame_t     cur
);

  scdk_pkg::frame_t cur_r;
  scdk_pkg::frame_t cur_nxt;

  // Advance when empty or when the neighbor takes the held beat
  assign free = !cur_r.valid || next_free;

  always_comb begin
    cur_nxt = cur_r;
    if (free) begin
      cur_nxt         = prev;
      cur_nxt.crc_acc = scdk_pkg::crc_step(prev.crc_acc ^ prev.pay[SEL], crc_poly);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

  assign cur = cur_r;

endmodule

`default_nettype wire
